// ===== hw/rtl/echoing_line_editor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echoing line editor checker
// Clocked on clk; the plain form is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECHOING_LINE_EDITOR_MACROS_SVH
`define ECHOING_LINE_EDITOR_MACROS_SVH

// Property checked out of reset only
`define ELE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("line editor assertion failed");

// Property checked on every edge, reset included
`define ELE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("line editor reset assertion failed");

`endif

// ===== hw/rtl/ele_pkg.sv =====
// ----------------------------------------------------------------------------
// ele_pkg
// Request and result types, character codes and the internal plan record
// shared by the line editor modules.
// ----------------------------------------------------------------------------
package ele_pkg;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // Reset value of the line limit register
  localparam logic [7:0] LIMIT_RST = 8'd128;

  // Request modes and result kinds
  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_char;
    logic [6:0] read_index;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_char;
    logic       line_done;
    logic [6:0] line_length;
    logic       last;
  } out_t;

  // What the emitter has to send for one request
  typedef enum logic [1:0] {
    PL_CHAR,   // echo of one stored character
    PL_EOL,    // CR LF with line length
    PL_ERASE,  // BS SP BS
    PL_READ    // one read data result
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t pk;
    logic [7:0] ch;
    logic [6:0] len;
    logic       rd_hit;
  } plan_t;

endpackage

// ===== hw/rtl/ele_front.sv =====
// ----------------------------------------------------------------------------
// ele_front
// Request decode, line state, line store and the plan register that hands
// each request's work to the emitter.
// ----------------------------------------------------------------------------
module ele_front #(
  parameter int LINE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ele_pkg::in_t     in_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output logic             plan_valid,
  output ele_pkg::plan_t   plan,
  output logic [7:0]       rd_data,
  input  logic             plan_take
);

  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int CapMax = (LINE_DEPTH - 1 < 127) ? LINE_DEPTH - 1 : 127;

  logic [7:0]           line_limit_r;
  logic [6:0]           count_r, count_nxt;
  logic [6:0]           done_len_r, done_len_nxt;
  logic                 plan_valid_r, plan_valid_nxt;
  ele_pkg::plan_t       plan_r, plan_nxt;
  logic [7:0]           mem [LINE_DEPTH];
  logic [7:0]           rd_q;

  logic                 accept;
  logic [7:0]           cap;
  logic                 below_cap;
  logic                 wr_en, rd_en;
  logic [AW+6:0]        wr_wide, rd_wide;
  logic [AW-1:0]        wr_addr, rd_addr;

  assign in_stall = plan_valid_r && !plan_take;
  assign accept   = in_valid && !in_stall;

  // Effective capacity: min(limit - 1, store depth - 1, 127)
  always_comb begin
    cap = (line_limit_r == 8'd0) ? 8'd0 : line_limit_r - 8'd1;
    if (cap > 8'(CapMax)) begin
      cap = 8'(CapMax);
    end
  end
  assign below_cap = {1'b0, count_r} < cap;

  // Store addresses from the 7-bit count and index
  assign wr_wide = {{AW{1'b0}}, count_r};
  assign rd_wide = {{AW{1'b0}}, in_data.read_index};
  assign wr_addr = wr_wide[AW-1:0];
  assign rd_addr = rd_wide[AW-1:0];

  // Decode of the accepted request
  always_comb begin
    count_nxt      = count_r;
    done_len_nxt   = done_len_r;
    plan_nxt       = plan_r;
    plan_valid_nxt = plan_take ? 1'b0 : plan_valid_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    if (accept) begin
      if (in_data.mode == ele_pkg::MODE_READ) begin
        rd_en          = 1'b1;
        plan_valid_nxt = 1'b1;
        plan_nxt.pk    = ele_pkg::PL_READ;
        plan_nxt.rd_hit = in_data.read_index < done_len_r;
      end else begin
        case (in_data.rx_char)
          ele_pkg::CH_CR, ele_pkg::CH_LF: begin
            plan_valid_nxt = 1'b1;
            plan_nxt.pk    = ele_pkg::PL_EOL;
            plan_nxt.len   = count_r;
            done_len_nxt   = count_r;
            count_nxt      = 7'd0;
          end
          ele_pkg::CH_BS, ele_pkg::CH_DEL: begin
            if (count_r != 7'd0) begin
              plan_valid_nxt = 1'b1;
              plan_nxt.pk    = ele_pkg::PL_ERASE;
              count_nxt      = count_r - 7'd1;
            end
          end
          default: begin
            if (in_data.rx_char inside {[ele_pkg::PRINT_LO:ele_pkg::PRINT_HI]}
                && below_cap) begin
              wr_en          = 1'b1;
              plan_valid_nxt = 1'b1;
              plan_nxt.pk    = ele_pkg::PL_CHAR;
              plan_nxt.ch    = in_data.rx_char;
              count_nxt      = count_r + 7'd1;
            end
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= ele_pkg::LIMIT_RST;
      count_r      <= 7'd0;
      done_len_r   <= 7'd0;
      plan_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_limit_r <= cfg_wdata;
      end
      count_r      <= count_nxt;
      done_len_r   <= done_len_nxt;
      plan_valid_r <= plan_valid_nxt;
    end
  end

  // Plan payload
  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
  end

  // Line store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.rx_char;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign plan_valid = plan_valid_r;
  assign plan       = plan_r;
  assign rd_data    = rd_q;

endmodule

// ===== hw/rtl/ele_emit.sv =====
// ----------------------------------------------------------------------------
// ele_emit
// Steps through the results of one plan, one per cycle while the result
// port is not stalled, into the result register.
// ----------------------------------------------------------------------------
module ele_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             plan_valid,
  input  ele_pkg::plan_t   plan,
  input  logic [7:0]       rd_data,
  output logic             plan_take,
  output logic             out_valid,
  input  logic             out_stall,
  output ele_pkg::out_t    out_data
);

  logic [1:0]     step_r, step_nxt;
  logic           out_valid_r, out_valid_nxt;
  ele_pkg::out_t  out_data_r, res;
  logic           load;
  logic           is_last;

  assign load = plan_valid && (!out_valid_r || !out_stall);

  // Result for the current step
  always_comb begin
    res             = '0;
    res.kind        = ele_pkg::KIND_ECHO;
    is_last         = 1'b1;
    case (plan.pk)
      ele_pkg::PL_CHAR: begin
        res.out_char = plan.ch;
      end
      ele_pkg::PL_EOL: begin
        is_last = (step_r == 2'd1);
        if (is_last) begin
          res.out_char    = ele_pkg::CH_LF;
          res.line_done   = 1'b1;
          res.line_length = plan.len;
        end else begin
          res.out_char = ele_pkg::CH_CR;
        end
      end
      ele_pkg::PL_ERASE: begin
        is_last      = (step_r == 2'd2);
        res.out_char = (step_r == 2'd1) ? ele_pkg::CH_SP : ele_pkg::CH_BS;
      end
      ele_pkg::PL_READ: begin
        res.kind     = ele_pkg::KIND_READ;
        res.out_char = plan.rd_hit ? rd_data : 8'd0;
      end
      default: begin
        res.out_char = 8'd0;
      end
    endcase
    res.last = is_last;
  end

  assign plan_take = load && is_last;

  // Step counter and result valid
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = is_last ? 2'd0 : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/echoing_line_editor.sv =====
// ----------------------------------------------------------------------------
// echoing_line_editor
// Terminal line editor: stores received characters in a line buffer, emits
// the echo characters and serves reads of the last completed line.
//
// Input channel (in_valid/in_stall/in_data): one request per received byte
// (mode 0) or per line read (mode 1). Result channel (out_*): echo bytes
// and read data, last set on the final result of a request. cfg_we/cfg_wdata
// write the line limit; write it only while the block is idle.
// Pipeline: two register stages, the plan register and then the result
// register; a request's first result reaches the result port through both.
// Throughput: one request per cycle while out_stall is low, for requests
// with at most one result; a request with n results (CR/LF: 2, erase: 3)
// holds the emitter while the output register takes them one per cycle.
// Reset: line empty, completed length zero, line limit 128, no result
// pending. The line store is not cleared; reads past the completed length
// return zero. When out_stall is high the result holds and in_stall rises
// as soon as the plan register is occupied.
// ----------------------------------------------------------------------------
module echoing_line_editor #(
  parameter int LINE_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ele_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ele_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  logic            plan_valid;
  ele_pkg::plan_t  plan;
  logic [7:0]      rd_data;
  logic            plan_take;

  // Decode, line state and store
  ele_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .plan_valid (plan_valid),
    .plan       (plan),
    .rd_data    (rd_data),
    .plan_take  (plan_take)
  );

  // Result sequencing
  ele_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (plan_valid),
    .plan       (plan),
    .rd_data    (rd_data),
    .plan_take  (plan_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/ele_chk.sv =====
// ----------------------------------------------------------------------------
// ele_chk
// Port-level checks on the line editor result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "echoing_line_editor_macros.svh"

module ele_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input ele_pkg::out_t  out_data
);

  // Nothing pending right after reset
  `ELE_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid)

  // A stalled result holds
  `ELE_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // Read data is a single, final result with no line report
  `ELE_ASSERT(a_read_single, out_valid && out_data.kind |-> out_data.last && !out_data.line_done)

  // Line done only on the final LF echo
  `ELE_ASSERT(a_done_lf, out_valid && out_data.line_done |-> !out_data.kind && out_data.last && out_data.out_char == ele_pkg::CH_LF)

  // The CR echo is never the final result of its request
  `ELE_ASSERT(a_cr_not_last, out_valid && !out_data.kind && out_data.out_char == ele_pkg::CH_CR |-> !out_data.last)

endmodule

bind echoing_line_editor ele_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for echoing_line_editor. Typed-in characters, erases,
// line ends and line reads are sent through the request channel; a local
// line model predicts every echo and read result, and a checker compares
// each delivered result with the oldest prediction. The line limit is
// changed between phases while the block is idle, and the sender idle and
// receiver stall rates vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STORE_DEPTH   = 128;
  localparam int QUIET_LIMIT   = 3000;  // cycles with no request or result moving
  localparam int SETTLE_CYCLES = 8;     // covers the pipeline and more

  // Line model and result checker
  class line_board;
    logic [7:0]     line_chars [STORE_DEPTH];
    int unsigned    fill_count;
    int unsigned    done_len;
    int unsigned    limit;
    ele_pkg::out_t  awaited[$];
    int unsigned    fail_count;

    function new();
      fill_count = 0;
      done_len   = 0;
      limit      = 32'(ele_pkg::LIMIT_RST);
      fail_count = 0;
    endfunction

    function void set_limit(logic [7:0] v);
      limit = 32'(v);
    endfunction

    // characters a line may hold under the current limit
    function int unsigned room();
      int unsigned keep;
      keep = (limit == 0) ? 0 : limit - 1;
      if (keep > STORE_DEPTH - 1) keep = STORE_DEPTH - 1;
      if (keep > 127) keep = 127;
      return keep;
    endfunction

    function ele_pkg::out_t make_result(logic kind, logic [7:0] ch, logic done,
                                        logic [6:0] len, logic fin);
      ele_pkg::out_t r;
      r.kind        = kind;
      r.out_char    = ch;
      r.line_done   = done;
      r.line_length = len;
      r.last        = fin;
      return r;
    endfunction

    // Updates the line and queues what the request should produce
    function int take_request(ele_pkg::in_t req);
      logic [7:0] c;
      logic [7:0] rd_val;
      c = req.rx_char;
      if (req.mode == ele_pkg::MODE_READ) begin
        rd_val = (req.read_index < done_len) ? line_chars[req.read_index] : 8'h00;
        awaited.push_back(make_result(ele_pkg::KIND_READ, rd_val, 1'b0, 7'd0, 1'b1));
        return 1;
      end
      // end of line: CR LF, length reported on LF
      if (c == ele_pkg::CH_CR || c == ele_pkg::CH_LF) begin
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, ele_pkg::CH_CR, 1'b0, 7'd0,
                                      1'b0));
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, ele_pkg::CH_LF, 1'b1,
                                      fill_count[6:0], 1'b1));
        done_len   = fill_count;
        fill_count = 0;
        return 2;
      end
      // erase: silent on an empty line
      if (c == ele_pkg::CH_BS || c == ele_pkg::CH_DEL) begin
        if (fill_count == 0) return 0;
        fill_count--;
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, ele_pkg::CH_BS, 1'b0, 7'd0,
                                      1'b0));
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, ele_pkg::CH_SP, 1'b0, 7'd0,
                                      1'b0));
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, ele_pkg::CH_BS, 1'b0, 7'd0,
                                      1'b1));
        return 3;
      end
      // printable: kept and echoed unless the line is full
      if (c >= ele_pkg::PRINT_LO && c <= ele_pkg::PRINT_HI && fill_count < room()) begin
        line_chars[fill_count[6:0]] = c;
        fill_count++;
        awaited.push_back(make_result(ele_pkg::KIND_ECHO, c, 1'b0, 7'd0, 1'b1));
        return 1;
      end
      return 0;
    endfunction

    function void check_result(ele_pkg::out_t got);
      ele_pkg::out_t want;
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with none pending: kind=%0d char=%02h done=%0d len=%0d last=%0d",
                   $time, got.kind, got.out_char, got.line_done, got.line_length, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.out_char !== want.out_char ||
          got.line_done !== want.line_done || got.line_length !== want.line_length ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch, expected kind=%0d char=%02h done=%0d len=%0d last=%0d",
                   $time, want.kind, want.out_char, want.line_done, want.line_length,
                   want.last);
          $display("%0t:           actual kind=%0d char=%02h done=%0d len=%0d last=%0d",
                   $time, got.kind, got.out_char, got.line_done, got.line_length, got.last);
        end
      end
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  ele_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ele_pkg::out_t  out_data;
  logic           cfg_we    = 1'b0;
  logic [7:0]     cfg_wdata = ele_pkg::LIMIT_RST;

  line_board   board = new();
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned quiet_cycles    = 0;

  echoing_line_editor #(.LINE_DEPTH(STORE_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check delivered results, stall at the phase's rate
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic ele_pkg::in_t rx_req(logic [7:0] c);
    ele_pkg::in_t r;
    r.mode       = ele_pkg::MODE_RX;
    r.rx_char    = c;
    r.read_index = 7'($urandom);
    return r;
  endfunction

  function automatic ele_pkg::in_t rd_req(logic [6:0] idx);
    ele_pkg::in_t r;
    r.mode       = ele_pkg::MODE_READ;
    r.rx_char    = 8'($urandom);
    r.read_index = idx;
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input ele_pkg::in_t req);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    void'(board.take_request(req));
  endtask

  // Hold off the sender until every pending result is delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_limit(v);
  endtask

  // Mostly typed lines with erases and reads of the finished line, some noise
  task automatic random_typing(input int unsigned n_req);
    int unsigned  pick;
    int unsigned  top;
    ele_pkg::in_t req;
    repeat (n_req) begin
      pick = $urandom_range(99);
      if (pick < 58)
        req = rx_req(8'($urandom_range(ele_pkg::PRINT_HI, ele_pkg::PRINT_LO)));
      else if (pick < 66)
        req = rx_req($urandom_range(1) ? ele_pkg::CH_BS : ele_pkg::CH_DEL);
      else if (pick < 76)
        req = rx_req($urandom_range(1) ? ele_pkg::CH_CR : ele_pkg::CH_LF);
      else if (pick < 88) begin
        top = (board.done_len + 1 > 127) ? 127 : board.done_len + 1;
        req = rd_req(7'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                  : $urandom_range(top)));
      end else
        req = rx_req(8'($urandom));
      send_request(req);
      if ($urandom_range(24) == 0) wait_drained();
    end
  endtask

  task automatic run_phase(input logic [7:0] lim, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_req);
    write_limit(lim);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    random_typing(n_req);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-line read and erases, ignored bytes, edit and read back
    send_request(rd_req(7'd0));
    send_request(rx_req(ele_pkg::CH_BS));
    send_request(rx_req(ele_pkg::CH_DEL));
    send_request(rx_req(8'h00));
    send_request(rx_req(8'hFF));
    send_request(rx_req(8'h80));
    send_request(rx_req(8'h1F));
    send_request(rx_req(ele_pkg::PRINT_LO));
    send_request(rx_req(ele_pkg::PRINT_HI));
    send_request(rx_req(8'h41));  // 'A'
    send_request(rx_req(ele_pkg::CH_BS));
    send_request(rx_req(ele_pkg::CH_DEL));
    send_request(rx_req(8'h5A));  // 'Z'
    send_request(rx_req(ele_pkg::CH_CR));
    send_request(rd_req(7'd0));
    send_request(rd_req(7'd1));
    send_request(rd_req(7'd2));   // just past the line
    send_request(rd_req(7'd127));
    send_request(rx_req(ele_pkg::CH_LF));  // empty line
    send_request(rd_req(7'd0));

    // Smallest limit that keeps a character: one character kept, the second dropped
    write_limit(8'd2);
    send_request(rx_req(8'h78));
    send_request(rx_req(8'h79));
    send_request(rx_req(ele_pkg::CH_CR));
    send_request(rd_req(7'd0));
    sender_idle_pct = 72;
    random_typing(12);

    // Zero limit: nothing is ever kept
    write_limit(8'd0);
    send_request(rx_req(8'h61));
    send_request(rx_req(ele_pkg::CH_CR));
    recv_stall_pct = 72;
    sender_idle_pct = 0;
    random_typing(12);

    run_phase(8'd255, 20, 20, 12);
    run_phase(8'd1, 0, 0, 12);
    run_phase(8'($urandom_range(128, 2)), 72, 0, 12);
    run_phase(8'd128, 0, 72, 12);
    run_phase(8'($urandom_range(10, 3)), 20, 20, 12);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.fail_count == 0 && board.awaited.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
